// ===== design/t2k_pkg.sv =====
// ---------------------------------------------------------------------------
// t2k_pkg
// Shared constants, register indexes, event codes and types for the
// tilt-to-key block.
// ---------------------------------------------------------------------------
package t2k_pkg;

    localparam int SAMPLE_W   = 16;
    localparam int FRAC_BITS  = 14;
    localparam int CENTER_W   = 18;
    localparam int CALC_W     = 20;
    localparam int THRESH_W   = 15;
    localparam int GAIN_W     = 17;
    localparam int PROD_W     = 2 * CENTER_W;
    localparam int CFG_DATA_W = 17;
    localparam int CFG_IDX_W  = 3;
    localparam int NUM_KEYS   = 6;
    localparam int KEY_IDX_W  = 3;
    localparam int AXIS_LIMIT = 32767;
    localparam int QDEPTH     = 2;

    localparam logic [CFG_IDX_W-1:0] REG_THRESH_X    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_Y    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_THRESH_Z    = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_AXIS_GAIN   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_CENTER_MODE = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_JOY_ENABLE  = 3'd5;
    localparam logic [CFG_IDX_W-1:0] REG_JOY_PRESENT = 3'd6;

    localparam logic [1:0] MODE_FLOAT   = 2'd0;
    localparam logic [1:0] MODE_CAPTURE = 2'd1;

    localparam logic [1:0] KIND_PRESS   = 2'd0;
    localparam logic [1:0] KIND_RELEASE = 2'd1;
    localparam logic [1:0] KIND_AXIS    = 2'd2;

    localparam logic [NUM_KEYS-1:0] JOY_AXES_MASK = 6'b000111;

    typedef struct packed {
        logic [THRESH_W-1:0] thresh_x;
        logic [THRESH_W-1:0] thresh_y;
        logic [THRESH_W-1:0] thresh_z;
        logic [GAIN_W-1:0]   axis_gain;
        logic [1:0]          center_mode;
        logic                joy_enable;
        logic                joy_present;
    } cfg_t;

    typedef struct packed {
        logic                       joy;
        logic [NUM_KEYS-1:0]        mask;
        logic [NUM_KEYS-1:0]        rel;
        logic signed [CENTER_W-1:0] d0;
        logic signed [CENTER_W-1:0] d1;
        logic signed [CENTER_W-1:0] d2;
    } job_t;

endpackage

// ===== design/t2k_intf.sv =====
// ---------------------------------------------------------------------------
// t2k_intf
// Valid/ready channels for tilt samples and for result events.
// ---------------------------------------------------------------------------
interface t2k_sample_if;
    import t2k_pkg::*;

    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] tilt_x;
    logic signed [SAMPLE_W-1:0] tilt_y;
    logic signed [SAMPLE_W-1:0] tilt_z;

    modport source (output valid, output tilt_x, output tilt_y, output tilt_z, input ready);
    modport sink (input valid, input tilt_x, input tilt_y, input tilt_z, output ready);
endinterface

interface t2k_event_if;
    import t2k_pkg::*;

    logic              valid;
    logic              ready;
    logic [1:0]        event_kind;
    logic [2:0]        key_code;
    logic [1:0]        axis_index;
    logic signed [15:0] axis_value;
    logic              last;

    modport source (output valid, output event_kind, output key_code, output axis_index,
                    output axis_value, output last, input ready);
    modport sink (input valid, input event_kind, input key_code, input axis_index,
                  input axis_value, input last, output ready);
endinterface

// ===== design/t2k_cfg.sv =====
// ---------------------------------------------------------------------------
// t2k_cfg
// Configuration register file with a plain write port.
// ---------------------------------------------------------------------------
module t2k_cfg (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [t2k_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [t2k_pkg::CFG_DATA_W-1:0] wr_data,
    output t2k_pkg::cfg_t                  cfg,
    output logic                           mode_wr
);
    import t2k_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.thresh_x    <= THRESH_W'(655);
            cfg_reg.thresh_y    <= THRESH_W'(1638);
            cfg_reg.thresh_z    <= THRESH_W'(1638);
            cfg_reg.axis_gain   <= GAIN_W'(400);
            cfg_reg.center_mode <= MODE_FLOAT;
            cfg_reg.joy_enable  <= 1'b0;
            cfg_reg.joy_present <= 1'b0;
        end
        else if (wr_en)
        begin
            case (wr_index)
                REG_THRESH_X:    cfg_reg.thresh_x    <= wr_data[THRESH_W-1:0];
                REG_THRESH_Y:    cfg_reg.thresh_y    <= wr_data[THRESH_W-1:0];
                REG_THRESH_Z:    cfg_reg.thresh_z    <= wr_data[THRESH_W-1:0];
                REG_AXIS_GAIN:   cfg_reg.axis_gain   <= wr_data[GAIN_W-1:0];
                REG_CENTER_MODE: cfg_reg.center_mode <= wr_data[1:0];
                REG_JOY_ENABLE:  cfg_reg.joy_enable  <= wr_data[0];
                REG_JOY_PRESENT: cfg_reg.joy_present <= wr_data[0];
                default:         cfg_reg.joy_present <= cfg_reg.joy_present;
            endcase
        end
    end

    assign cfg     = cfg_reg;
    assign mode_wr = wr_en && (wr_index == REG_CENTER_MODE);

endmodule

// ===== design/t2k_front.sv =====
// ---------------------------------------------------------------------------
// t2k_front
// Accepts tilt samples, updates the centers and key flags, and turns each
// sample that causes events into one job of pending events for the back end.
// ---------------------------------------------------------------------------
module t2k_front (
    input  logic          clk,
    input  logic          rst_n,
    t2k_sample_if.sink    samples,
    input  t2k_pkg::cfg_t cfg,
    input  logic          mode_wr,
    input  logic          q_full,
    output logic          push,
    output t2k_pkg::job_t push_job
);
    import t2k_pkg::*;

    typedef struct packed {
        logic signed [CALC_W-1:0] c;
        logic [1:0]               act;
        logic [1:0]               ev;
    } axis_res_t;

    function automatic axis_res_t key_axis(input logic signed [CALC_W-1:0] s,
                                           input logic signed [CALC_W-1:0] c,
                                           input logic [THRESH_W-1:0] t,
                                           input logic [1:0] held);
        logic signed [CALC_W-1:0] t1;
        logic signed [CALC_W-1:0] t2;
        logic signed [CALC_W-1:0] c1;
        axis_res_t                r;
        t1       = $signed({{(CALC_W-THRESH_W){1'b0}}, t});
        t2       = t1 <<< 1;
        r.act[0] = s < c - t1;
        c1       = (s < c - t2) ? s + t2 : c;
        r.act[1] = s > c1 + t1;
        r.c      = (s > c1 + t2) ? s - t2 : c1;
        r.ev     = r.act ^ held;
        return r;
    endfunction

    logic signed [CENTER_W-1:0] center_x_reg, center_y_reg, center_z_reg;
    logic signed [CENTER_W-1:0] center_x_next, center_y_next, center_z_next;
    logic [NUM_KEYS-1:0]        pressed_reg, pressed_next;
    logic                       captured_reg, captured_next;

    logic                       accept;
    logic                       capture;
    logic                       follow;
    logic signed [CALC_W-1:0]   sx, sy, sz;
    logic signed [CALC_W-1:0]   cx0, cy0, cz0;
    logic signed [CALC_W-1:0]   dx, dy, dz;
    axis_res_t                  kx, ky, kz;
    job_t                       job;
    logic                       has_events;

    assign sx = {{(CALC_W-SAMPLE_W){samples.tilt_x[SAMPLE_W-1]}}, samples.tilt_x};
    assign sy = {{(CALC_W-SAMPLE_W){samples.tilt_y[SAMPLE_W-1]}}, samples.tilt_y};
    assign sz = {{(CALC_W-SAMPLE_W){samples.tilt_z[SAMPLE_W-1]}}, samples.tilt_z};

    assign capture = (cfg.center_mode == MODE_CAPTURE) && !captured_reg;

    assign cx0 = capture ? sx : {{(CALC_W-CENTER_W){center_x_reg[CENTER_W-1]}}, center_x_reg};
    assign cy0 = capture ? sy : {{(CALC_W-CENTER_W){center_y_reg[CENTER_W-1]}}, center_y_reg};
    assign cz0 = capture ? sz : {{(CALC_W-CENTER_W){center_z_reg[CENTER_W-1]}}, center_z_reg};

    assign kx = key_axis(sx, cx0, cfg.thresh_x, pressed_reg[1:0]);
    assign ky = key_axis(sy, cy0, cfg.thresh_y, pressed_reg[3:2]);
    assign kz = key_axis(sz, cz0, cfg.thresh_z, pressed_reg[5:4]);

    assign dx = cx0 - sx;
    assign dy = sy - cy0;
    assign dz = sz - cz0;

    assign follow = cfg.joy_present && (cfg.center_mode == MODE_FLOAT);

    always_comb
    begin
        job.joy = cfg.joy_enable;
        job.d0  = dx[CENTER_W-1:0];
        job.d1  = dy[CENTER_W-1:0];
        job.d2  = dz[CENTER_W-1:0];
        if (cfg.joy_enable)
        begin
            job.mask   = JOY_AXES_MASK;
            job.rel    = '0;
            has_events = cfg.joy_present;
        end
        else
        begin
            job.mask   = {kz.ev, ky.ev, kx.ev};
            job.rel    = ~{kz.act, ky.act, kx.act};
            has_events = |job.mask;
        end
    end

    always_comb
    begin
        center_x_next = center_x_reg;
        center_y_next = center_y_reg;
        center_z_next = center_z_reg;
        pressed_next  = pressed_reg;
        captured_next = captured_reg;
        if (accept)
        begin
            captured_next = captured_reg || capture;
            if (cfg.joy_enable)
            begin
                center_x_next = cx0[CENTER_W-1:0];
                center_y_next = follow ? ky.c[CENTER_W-1:0] : cy0[CENTER_W-1:0];
                center_z_next = follow ? kz.c[CENTER_W-1:0] : cz0[CENTER_W-1:0];
            end
            else
            begin
                center_x_next = kx.c[CENTER_W-1:0];
                center_y_next = ky.c[CENTER_W-1:0];
                center_z_next = kz.c[CENTER_W-1:0];
                pressed_next  = {kz.act, ky.act, kx.act};
            end
        end
        if (mode_wr)
        begin
            captured_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            center_x_reg <= '0;
            center_y_reg <= '0;
            center_z_reg <= '0;
            pressed_reg  <= '0;
            captured_reg <= 1'b0;
        end
        else
        begin
            center_x_reg <= center_x_next;
            center_y_reg <= center_y_next;
            center_z_reg <= center_z_next;
            pressed_reg  <= pressed_next;
            captured_reg <= captured_next;
        end
    end

    assign samples.ready = !q_full;
    assign accept        = samples.valid && samples.ready;
    assign push          = accept && has_events;
    assign push_job      = job;

endmodule

// ===== design/t2k_queue.sv =====
// ---------------------------------------------------------------------------
// t2k_queue
// Small job queue between the front end and the back end.
// ---------------------------------------------------------------------------
module t2k_queue (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          push,
    input  t2k_pkg::job_t push_job,
    output logic          full,
    input  logic          pop,
    output logic          not_empty,
    output t2k_pkg::job_t pop_job
);
    import t2k_pkg::*;

    localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int CNT_W = $clog2(QDEPTH + 1);

    job_t             mem [QDEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, rd_ptr_reg;
    logic [CNT_W-1:0] count_reg;
    logic             do_push, do_pop;

    assign full      = (count_reg == CNT_W'(QDEPTH));
    assign not_empty = (count_reg != '0);
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_job   = mem[rd_ptr_reg];

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem[wr_ptr_reg] <= push_job;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                count_reg <= count_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                count_reg <= count_reg - 1'b1;
            end
        end
    end

endmodule

// ===== design/t2k_back.sv =====
// ---------------------------------------------------------------------------
// t2k_back
// Walks one job at a time and issues its events through a multiply stage and
// a saturating output register, one per cycle while the receiver is ready.
// ---------------------------------------------------------------------------
module t2k_back (
    input  logic          clk,
    input  logic          rst_n,
    input  t2k_pkg::cfg_t cfg,
    input  logic          q_not_empty,
    input  t2k_pkg::job_t q_job,
    output logic          q_pop,
    t2k_event_if.source   events
);
    import t2k_pkg::*;

    job_t                     cur_reg;
    logic                     cur_valid_reg;
    logic [NUM_KEYS-1:0]      rem_reg;

    logic                     mid_valid_reg;
    logic [1:0]               mid_kind_reg;
    logic [KEY_IDX_W-1:0]     mid_key_reg;
    logic [1:0]               mid_axis_reg;
    logic signed [PROD_W-1:0] mid_prod_reg;
    logic                     mid_last_reg;

    logic                     out_valid_reg;
    logic [1:0]               out_kind_reg;
    logic [2:0]               out_key_reg;
    logic [1:0]               out_axis_reg;
    logic signed [15:0]       out_value_reg;
    logic                     out_last_reg;

    logic [KEY_IDX_W-1:0]     idx;
    logic [NUM_KEYS-1:0]      rest;
    logic                     cur_last;
    logic                     out_adv, mid_adv, issue;
    logic signed [CENTER_W-1:0] dsel;
    logic signed [CENTER_W-1:0] gain_s;
    logic signed [PROD_W-1:0] prod;
    logic                     neg;
    logic [PROD_W-1:0]        mag;
    logic [PROD_W-1:0]        mag_sh;
    logic [15:0]              mag_sat;
    logic signed [15:0]       value;

    always_comb
    begin
        idx = '0;
        for (int i = NUM_KEYS - 1; i >= 0; i--)
        begin
            if (rem_reg[i])
            begin
                idx = KEY_IDX_W'(i);
            end
        end
    end

    assign rest     = rem_reg & ~(NUM_KEYS'(1) << idx);
    assign cur_last = (rest == '0);

    assign out_adv = !out_valid_reg || events.ready;
    assign mid_adv = !mid_valid_reg || out_adv;
    assign issue   = cur_valid_reg && mid_adv;
    assign q_pop   = q_not_empty && (!cur_valid_reg || (issue && cur_last));

    always_comb
    begin
        case (idx[1:0])
            2'd0:    dsel = cur_reg.d0;
            2'd1:    dsel = cur_reg.d1;
            default: dsel = cur_reg.d2;
        endcase
    end

    assign gain_s = $signed({{(CENTER_W-GAIN_W){1'b0}}, cfg.axis_gain});

    always_comb
    begin
        prod = '0;
        if (cur_reg.joy)
        begin
            prod = dsel * gain_s;
        end
    end

    always_ff @(posedge clk)
    begin
        if (q_pop)
        begin
            cur_reg <= q_job;
        end
        if (issue)
        begin
            mid_kind_reg <= cur_reg.joy ? KIND_AXIS :
                            (cur_reg.rel[idx] ? KIND_RELEASE : KIND_PRESS);
            mid_key_reg  <= cur_reg.joy ? '0 : idx;
            mid_axis_reg <= cur_reg.joy ? idx[1:0] : 2'd0;
            mid_prod_reg <= prod;
            mid_last_reg <= cur_last;
        end
    end

    assign neg     = mid_prod_reg[PROD_W-1];
    assign mag     = neg ? PROD_W'(-mid_prod_reg) : PROD_W'(mid_prod_reg);
    assign mag_sh  = mag >> FRAC_BITS;
    assign mag_sat = (mag_sh > PROD_W'(AXIS_LIMIT)) ? 16'(AXIS_LIMIT) : mag_sh[15:0];
    assign value   = neg ? -$signed(mag_sat) : $signed(mag_sat);

    always_ff @(posedge clk)
    begin
        if (out_adv && mid_valid_reg)
        begin
            out_kind_reg  <= mid_kind_reg;
            out_key_reg   <= mid_key_reg;
            out_axis_reg  <= mid_axis_reg;
            out_value_reg <= value;
            out_last_reg  <= mid_last_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_valid_reg <= 1'b0;
            rem_reg       <= '0;
            mid_valid_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (q_pop)
            begin
                cur_valid_reg <= 1'b1;
                rem_reg       <= q_job.mask;
            end
            else if (issue)
            begin
                cur_valid_reg <= !cur_last;
                rem_reg       <= rest;
            end
            if (issue)
            begin
                mid_valid_reg <= 1'b1;
            end
            else if (out_adv)
            begin
                mid_valid_reg <= 1'b0;
            end
            if (out_adv)
            begin
                out_valid_reg <= mid_valid_reg;
            end
        end
    end

    assign events.valid      = out_valid_reg;
    assign events.event_kind = out_kind_reg;
    assign events.key_code   = out_key_reg;
    assign events.axis_index = out_axis_reg;
    assign events.axis_value = out_value_reg;
    assign events.last       = out_last_reg;

endmodule

// ===== design/tilt_to_key_hysteresis.sv =====
// ---------------------------------------------------------------------------
// tilt_to_key_hysteresis
// Turns three-axis tilt samples into key press/release events or joystick
// axis values, with a per-axis center that floats or is captured from a sample.
// ---------------------------------------------------------------------------
// The first event of a sample passes through the job queue, the current-job
// register, the multiply stage and the output register; further events follow
// one per cycle while the receiver is ready. A sample causes at most six events;
// the job queue holds two samples so the front end keeps accepting meanwhile.
// Samples that cause no event never enter the queue.
// Reset clears the centers, key flags, capture flag and queue, and loads
// the register defaults; the sample input is ready as soon as reset is released.
module tilt_to_key_hysteresis (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           wr_en,
    input  logic [t2k_pkg::CFG_IDX_W-1:0]  wr_index,
    input  logic [t2k_pkg::CFG_DATA_W-1:0] wr_data,
    t2k_sample_if.sink                     samples,
    t2k_event_if.source                    events
);
    import t2k_pkg::*;

    cfg_t cfg;
    logic mode_wr;
    logic push, q_full, q_pop, q_not_empty;
    job_t push_job, q_job;

    t2k_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .cfg      (cfg),
        .mode_wr  (mode_wr)
    );

    t2k_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .samples  (samples),
        .cfg      (cfg),
        .mode_wr  (mode_wr),
        .q_full   (q_full),
        .push     (push),
        .push_job (push_job)
    );

    t2k_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_job  (push_job),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .pop_job   (q_job)
    );

    t2k_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg         (cfg),
        .q_not_empty (q_not_empty),
        .q_job       (q_job),
        .q_pop       (q_pop),
        .events      (events)
    );

endmodule

// ===== tb/tilt_to_key_hysteresis_test.sv =====
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tilt_to_key_hysteresis_test
// Self-checking bench for the tilt-to-key block. Sample transactions are
// fed through the valid/ready input channel. An in-bench predictor keeps
// its own copy of the registers, centers and key flags, and computes the
// expected key and joystick events for each accepted sample. A checker
// compares each result transaction field by field against the oldest
// expected event. Directed tests cover extremes, every mode and the corner
// cases. Random phases then vary the register setup and walk the samples
// in threshold-sized steps. Both sides idle at random, and one long receiver
// hold-off fills the block until it stalls its input.
// ---------------------------------------------------------------------------
module tilt_to_key_hysteresis_test;
    import t2k_pkg::*;

    localparam int CLK_HALF       = 2;
    localparam int RESET_CYCLES   = 9;
    localparam int SETTLE_CYCLES  = 8;
    localparam int HOLD_CYCLES    = 300;
    localparam int TIMEOUT_CYCLES = 200000;
    localparam int RANDOM_PHASES  = 5;
    localparam int PHASE_SAMPLES  = 15;

    localparam logic [1:0] MODE_FIXED = 2'd2;
    localparam logic [1:0] MODE_SPARE = 2'd3;

    localparam logic [KEY_IDX_W-1:0] KEY_NONE     = 3'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_LEFT     = 3'd0;
    localparam logic [KEY_IDX_W-1:0] KEY_DOWN     = 3'd2;
    localparam logic [KEY_IDX_W-1:0] KEY_ALT_LEFT = 3'd4;

    localparam logic [1:0] AXIS_NONE = 2'd0;
    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_Z    = 2'd2;

    typedef struct packed {
        logic [1:0]           kind;
        logic [KEY_IDX_W-1:0] key;
        logic [1:0]           axis;
        logic signed [15:0]   value;
        logic                 last;
    } tilt_event_t;

    logic                  clk;
    logic                  rst_n;
    logic                  wr_en;
    logic [CFG_IDX_W-1:0]  wr_index;
    logic [CFG_DATA_W-1:0] wr_data;

    t2k_sample_if sample_ch ();
    t2k_event_if  event_ch ();

    cfg_t                       cfg;
    logic signed [CENTER_W-1:0] center_x;
    logic signed [CENTER_W-1:0] center_y;
    logic signed [CENTER_W-1:0] center_z;
    logic [NUM_KEYS-1:0]        held_keys;
    logic                       captured;

    tilt_event_t pending_events[$];
    tilt_event_t sample_events[$];

    int error_count = 0;
    int cycle_count = 0;
    bit tx_idle;
    bit rx_idle;
    bit hold_request;

    tilt_to_key_hysteresis u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .wr_en    (wr_en),
        .wr_index (wr_index),
        .wr_data  (wr_data),
        .samples  (sample_ch),
        .events   (event_ch)
    );

    always
    begin
        clk = 1'b0;
        #CLK_HALF;
        clk = 1'b1;
        #CLK_HALF;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= TIMEOUT_CYCLES)
        begin
            $display("tilt_to_key_hysteresis_test: done, errors");
            $finish;
        end
    end

    function automatic tilt_event_t make_event(input logic [1:0] kind,
                                               input logic [KEY_IDX_W-1:0] key,
                                               input logic [1:0] axis,
                                               input logic signed [15:0] value);
        tilt_event_t ev;
        ev.kind  = kind;
        ev.key   = key;
        ev.axis  = axis;
        ev.value = value;
        ev.last  = 1'b0;
        return ev;
    endfunction

    function automatic void note_key(input bit active, input logic [KEY_IDX_W-1:0] key);
        if (active && !held_keys[key])
        begin
            held_keys[key] = 1'b1;
            sample_events.push_back(make_event(KIND_PRESS, key, AXIS_NONE, 16'sd0));
        end
        else if (!active && held_keys[key])
        begin
            held_keys[key] = 1'b0;
            sample_events.push_back(make_event(KIND_RELEASE, key, AXIS_NONE, 16'sd0));
        end
    endfunction

    function automatic void key_axis(input int s, inout logic signed [CENTER_W-1:0] c,
                                     input int t, input logic [KEY_IDX_W-1:0] neg_key);
        int cc;
        cc = c;
        note_key(s < cc - t, neg_key);
        if (s < cc - 2 * t)
            cc = s + 2 * t;
        note_key(s > cc + t, neg_key + 3'd1);
        if (s > cc + 2 * t)
            cc = s - 2 * t;
        c = cc;
    endfunction

    function automatic void follow_center(input int s, inout logic signed [CENTER_W-1:0] c,
                                          input int t);
        int cc;
        cc = c;
        if (s < cc - 2 * t)
            cc = s + 2 * t;
        if (s > cc + 2 * t)
            cc = s - 2 * t;
        c = cc;
    endfunction

    function automatic logic signed [15:0] scale_axis(input longint d);
        longint prod;
        longint mag;
        prod = d * longint'(cfg.axis_gain);
        mag  = (prod < 0) ? -prod : prod;
        mag  = mag >> FRAC_BITS;
        if (mag > AXIS_LIMIT)
            mag = AXIS_LIMIT;
        return 16'((prod < 0) ? -mag : mag);
    endfunction

    function automatic void predict_tilt_events(input logic signed [SAMPLE_W-1:0] x,
                                                input logic signed [SAMPLE_W-1:0] y,
                                                input logic signed [SAMPLE_W-1:0] z);
        int sx;
        int sy;
        int sz;
        sx = x;
        sy = y;
        sz = z;
        sample_events.delete();
        if (cfg.center_mode == MODE_CAPTURE && !captured)
        begin
            captured = 1'b1;
            center_x = sx;
            center_y = sy;
            center_z = sz;
        end
        if (cfg.joy_enable)
        begin
            if (cfg.joy_present)
            begin
                sample_events.push_back(make_event(KIND_AXIS, KEY_NONE, AXIS_X,
                                                   scale_axis(longint'(center_x) - sx)));
                sample_events.push_back(make_event(KIND_AXIS, KEY_NONE, AXIS_Y,
                                                   scale_axis(sy - longint'(center_y))));
                sample_events.push_back(make_event(KIND_AXIS, KEY_NONE, AXIS_Z,
                                                   scale_axis(sz - longint'(center_z))));
                if (cfg.center_mode == MODE_FLOAT)
                begin
                    follow_center(sy, center_y, cfg.thresh_y);
                    follow_center(sz, center_z, cfg.thresh_z);
                end
            end
        end
        else
        begin
            key_axis(sx, center_x, cfg.thresh_x, KEY_LEFT);
            key_axis(sy, center_y, cfg.thresh_y, KEY_DOWN);
            key_axis(sz, center_z, cfg.thresh_z, KEY_ALT_LEFT);
        end
        if (sample_events.size() > 0)
            sample_events[sample_events.size() - 1].last = 1'b1;
        foreach (sample_events[i])
            pending_events.push_back(sample_events[i]);
    endfunction

    function automatic void apply_register(input logic [CFG_IDX_W-1:0] idx,
                                           input logic [CFG_DATA_W-1:0] data);
        case (idx)
            REG_THRESH_X:    cfg.thresh_x = data[THRESH_W-1:0];
            REG_THRESH_Y:    cfg.thresh_y = data[THRESH_W-1:0];
            REG_THRESH_Z:    cfg.thresh_z = data[THRESH_W-1:0];
            REG_AXIS_GAIN:   cfg.axis_gain = data[GAIN_W-1:0];
            REG_CENTER_MODE:
            begin
                cfg.center_mode = data[1:0];
                captured = 1'b0;
            end
            REG_JOY_ENABLE:  cfg.joy_enable = data[0];
            REG_JOY_PRESENT: cfg.joy_present = data[0];
            default: ;
        endcase
    endfunction

    function automatic void check_field(input string name, input logic signed [16:0] want,
                                        input logic signed [16:0] got);
        if (got !== want)
        begin
            $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge clk)
    begin : check_events
        tilt_event_t want;
        if (rst_n === 1'b1 && event_ch.valid === 1'b1 && event_ch.ready === 1'b1)
        begin
            if (pending_events.size() == 0)
            begin
                $display("%0t: unexpected event kind=%0d key=%0d axis=%0d value=%0d last=%0d",
                         $time, event_ch.event_kind, event_ch.key_code, event_ch.axis_index,
                         event_ch.axis_value, event_ch.last);
                error_count++;
            end
            else
            begin
                want = pending_events.pop_front();
                check_field("event_kind", want.kind, event_ch.event_kind);
                check_field("key_code", want.key, event_ch.key_code);
                check_field("axis_index", want.axis, event_ch.axis_index);
                check_field("axis_value", want.value, event_ch.axis_value);
                check_field("last", want.last, event_ch.last);
            end
        end
    end

    initial
    begin : event_receiver
        int stall;
        event_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_request)
            begin
                hold_request = 1'b0;
                event_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                stall = rx_idle ? $urandom_range(0, 8) : 0;
                if (stall > 0)
                begin
                    event_ch.ready <= 1'b0;
                    repeat (stall) @(posedge clk);
                end
            end
            event_ch.ready <= 1'b1;
            do
                @(posedge clk);
            while (!(event_ch.valid === 1'b1 && event_ch.ready === 1'b1));
        end
    end

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        wr_en    <= 1'b1;
        wr_index <= idx;
        wr_data  <= data;
        @(posedge clk);
        apply_register(idx, data);
        wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x,
                               input logic signed [SAMPLE_W-1:0] y,
                               input logic signed [SAMPLE_W-1:0] z);
        int gap;
        gap = tx_idle ? $urandom_range(0, 8) : 0;
        if (gap > 0)
        begin
            sample_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        sample_ch.valid  <= 1'b1;
        sample_ch.tilt_x <= x;
        sample_ch.tilt_y <= y;
        sample_ch.tilt_z <= z;
        do
            @(posedge clk);
        while (!(sample_ch.valid === 1'b1 && sample_ch.ready === 1'b1));
        predict_tilt_events(x, y, z);
    endtask

    task automatic wait_idle();
        sample_ch.valid <= 1'b0;
        while (pending_events.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic signed [SAMPLE_W-1:0] wander(input logic signed [SAMPLE_W-1:0] prev,
                                                          input int t);
        int span;
        int v;
        span = 3 * t + 1;
        if (span > 40000)
            span = 40000;
        v = int'(prev) + int'($urandom_range(0, 2 * span)) - span;
        if (v > 32767)
            v = 32767;
        if (v < -32768)
            v = -32768;
        return 16'(v);
    endfunction

    function automatic logic [CFG_DATA_W-1:0] pick_thresh();
        int value;
        case ($urandom_range(0, 5))
            0:       value = 0;
            1:       value = 32767;
            2:       value = 16384;
            5:       value = $urandom_range(0, 32767);
            default: value = $urandom_range(0, 2000);
        endcase
        return {2'($urandom_range(0, 3)), 15'(value)};
    endfunction

    task automatic test_key_extremes();
        send_sample(0, 0, 0);
        send_sample(-32768, 32767, -32768);
        send_sample(32767, -32768, 32767);
        send_sample(0, 0, 0);
        send_sample(-1, -1, -1);
        wait_idle();
    endtask

    task automatic test_thresholds();
        write_reg(REG_THRESH_X, '0);
        write_reg(REG_THRESH_Y, 17'h1FFFF);
        write_reg(REG_THRESH_Z, 17'd16384);
        send_sample(1, 1, 1);
        send_sample(-1, -1, -1);
        send_sample(0, 0, 0);
        send_sample(-32768, 32767, 16385);
        wait_idle();
    endtask

    task automatic test_joystick_scaling();
        write_reg(REG_AXIS_GAIN, 17'h1FFFF);
        write_reg(REG_CENTER_MODE, MODE_FLOAT);
        write_reg(REG_JOY_ENABLE, 17'd1);
        write_reg(REG_JOY_PRESENT, 17'd1);
        send_sample(32767, -32768, 0);
        send_sample(-32768, 32767, -1);
        wait_idle();
        write_reg(REG_AXIS_GAIN, 17'd1);
        send_sample(-16385, 16385, -1);
        send_sample(16383, -16383, 1);
        wait_idle();
        write_reg(REG_AXIS_GAIN, '0);
        send_sample(123, -456, 789);
        wait_idle();
    endtask

    task automatic test_center_modes();
        write_reg(REG_AXIS_GAIN, 17'd400);
        write_reg(REG_CENTER_MODE, MODE_CAPTURE);
        send_sample(8000, -8000, 4000);
        send_sample(9000, -7000, 3000);
        wait_idle();
        write_reg(REG_CENTER_MODE, MODE_CAPTURE);
        send_sample(-5000, 5000, 0);
        send_sample(0, 0, 0);
        wait_idle();
        write_reg(REG_CENTER_MODE, MODE_FIXED);
        send_sample(1000, 1000, 1000);
        wait_idle();
        write_reg(REG_CENTER_MODE, MODE_SPARE);
        send_sample(-20000, 20000, -20000);
        send_sample(0, 0, 0);
        wait_idle();
    endtask

    task automatic test_joystick_without_sink();
        write_reg(REG_JOY_PRESENT, '0);
        send_sample(32767, -32768, 12345);
        send_sample(-32768, 32767, -12345);
        send_sample(0, 0, 0);
        wait_idle();
        write_reg(REG_JOY_ENABLE, '0);
        write_reg(REG_JOY_PRESENT, 17'd1);
    endtask

    task automatic test_backpressure();
        int sign;
        write_reg(REG_THRESH_X, 17'd100);
        write_reg(REG_THRESH_Y, 17'd100);
        write_reg(REG_THRESH_Z, 17'd100);
        write_reg(REG_CENTER_MODE, MODE_FLOAT);
        tx_idle = 1'b0;
        hold_request = 1'b1;
        sign = 1;
        repeat (12)
        begin
            send_sample(16'(sign * (20000 + int'($urandom_range(0, 100)))),
                        16'(-sign * (20000 + int'($urandom_range(0, 100)))),
                        16'(sign * (20000 + int'($urandom_range(0, 100)))));
            sign = -sign;
        end
        wait_idle();
        tx_idle = 1'b1;
    endtask

    task automatic test_random_phases();
        logic signed [SAMPLE_W-1:0] wx;
        logic signed [SAMPLE_W-1:0] wy;
        logic signed [SAMPLE_W-1:0] wz;
        bit joy;
        repeat (RANDOM_PHASES)
        begin
            write_reg(REG_THRESH_X, pick_thresh());
            write_reg(REG_THRESH_Y, pick_thresh());
            write_reg(REG_THRESH_Z, pick_thresh());
            case ($urandom_range(0, 3))
                0:       write_reg(REG_AXIS_GAIN, '0);
                1:       write_reg(REG_AXIS_GAIN, 17'h1FFFF);
                default: write_reg(REG_AXIS_GAIN, 17'($urandom_range(1, 2000)));
            endcase
            write_reg(REG_CENTER_MODE, 17'($urandom));
            joy = ($urandom_range(0, 2) == 0);
            write_reg(REG_JOY_ENABLE, {16'($urandom), joy});
            write_reg(REG_JOY_PRESENT, {16'($urandom), joy | 1'($urandom)});
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);
            wx = 16'($urandom);
            wy = 16'($urandom);
            wz = 16'($urandom);
            repeat (PHASE_SAMPLES)
            begin
                if ($urandom_range(0, 4) == 0)
                begin
                    wx = 16'($urandom);
                    wy = 16'($urandom);
                    wz = 16'($urandom);
                end
                else
                begin
                    wx = wander(wx, cfg.thresh_x);
                    wy = wander(wy, cfg.thresh_y);
                    wz = wander(wz, cfg.thresh_z);
                end
                send_sample(wx, wy, wz);
            end
            wait_idle();
        end
    endtask

    initial
    begin
        rst_n            <= 1'b0;
        wr_en            <= 1'b0;
        wr_index         <= '0;
        wr_data          <= '0;
        sample_ch.valid  <= 1'b0;
        sample_ch.tilt_x <= '0;
        sample_ch.tilt_y <= '0;
        sample_ch.tilt_z <= '0;
        tx_idle          = 1'b1;
        rx_idle          = 1'b1;
        hold_request     = 1'b0;
        cfg.thresh_x     = 15'd655;
        cfg.thresh_y     = 15'd1638;
        cfg.thresh_z     = 15'd1638;
        cfg.axis_gain    = 17'd400;
        cfg.center_mode  = MODE_FLOAT;
        cfg.joy_enable   = 1'b0;
        cfg.joy_present  = 1'b0;
        center_x         = '0;
        center_y         = '0;
        center_z         = '0;
        held_keys        = '0;
        captured         = 1'b0;
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        repeat (2) @(posedge clk);

        test_key_extremes();
        test_thresholds();
        test_joystick_scaling();
        test_center_modes();
        test_joystick_without_sink();
        test_backpressure();
        test_random_phases();

        if (error_count == 0)
            $display("tilt_to_key_hysteresis_test: done, clean");
        else
            $display("tilt_to_key_hysteresis_test: done, errors");
        $finish;
    end

endmodule
